FILE: rtl/core/gtp_pkg.sv
// Shared types and constants for the gradient test pattern pixel pipeline.
`timescale 1ns / 1ps

package gtp_pkg;

    // Field widths
    localparam int COORD_W   = 12;
    localparam int DIM_W     = 13;
    localparam int QUO_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Default for the largest usable frame dimension
    localparam int MAX_DIMENSION_DEF = 4096;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd2;

    // Color mode codes
    localparam logic MODE_RGB565 = 1'b0;
    localparam logic MODE_RGB888 = 1'b1;

    // Reset values
    localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd800;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd480;

    // Overlay colors
    localparam logic [4:0] RED_FULL   = 5'd31;
    localparam logic [7:0] GREEN_LINE = 8'd63;

    // Input item
    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
    } t_pix_in;

    // Result item
    typedef struct packed {
        logic [4:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       in_range;
    } t_pix_out;

    // Frame geometry seen by the pipeline (dimensions already saturated)
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             mode;
    } t_geom;

    // Per-item work carried down the divider stages
    typedef struct packed {
        logic             in_range;
        logic             border;
        logic             col_line;
        logic [DIM_W-1:0] rem_g;
        logic [DIM_W-1:0] rem_b;
        logic [QUO_W-1:0] quo_g;
        logic [QUO_W-1:0] quo_b;
    } t_work;

endpackage

FILE: rtl/core/gtp_cfg.sv
// Configuration registers with dimension saturation.
`timescale 1ns / 1ps

module gtp_cfg #(
    parameter int MAX_DIMENSION = gtp_pkg::MAX_DIMENSION_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gtp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gtp_pkg::DIM_W-1:0]      i_cfg_data,
    output gtp_pkg::t_geom                 o_geom
);

    localparam int DIM_TOP = (1 << gtp_pkg::DIM_W) - 1;
    localparam logic [gtp_pkg::DIM_W-1:0] SAT_DIM =
        (MAX_DIMENSION > DIM_TOP) ? gtp_pkg::DIM_W'(DIM_TOP) : gtp_pkg::DIM_W'(MAX_DIMENSION);

    gtp_pkg::t_geom            r_geom;
    logic [gtp_pkg::DIM_W-1:0] n_dim;
    logic                      cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;

    // Only the saturated dimension is ever used, so store that
    assign n_dim = (i_cfg_data > SAT_DIM) ? SAT_DIM : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.width  <= gtp_pkg::WIDTH_RST;
            r_geom.height <= gtp_pkg::HEIGHT_RST;
            r_geom.mode   <= gtp_pkg::MODE_RGB565;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                gtp_pkg::CFG_FRAME_WIDTH:  r_geom.width  <= n_dim;
                gtp_pkg::CFG_FRAME_HEIGHT: r_geom.height <= n_dim;
                gtp_pkg::CFG_COLOR_MODE:   r_geom.mode   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_geom = r_geom;

endmodule

FILE: rtl/core/gtp_div_step.sv
// One restoring division step for both ramps, as a registered pipeline stage.
`timescale 1ns / 1ps

module gtp_div_step (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gtp_pkg::t_geom            i_geom,
    input  logic                      i_valid,
    input  gtp_pkg::t_work            i_work,
    output logic                      o_ready,
    output logic                      o_valid,
    output gtp_pkg::t_work            o_work,
    input  logic                      i_ready_dn
);

    logic                      r_valid;
    gtp_pkg::t_work            r_work;
    gtp_pkg::t_work            n_work;
    logic [gtp_pkg::DIM_W:0]   rem2_g;
    logic [gtp_pkg::DIM_W:0]   rem2_b;
    logic                      bit_g;
    logic                      bit_b;

    // Remainder stays below the divisor, so one compare and subtract per bit
    assign rem2_g = {i_work.rem_g, 1'b0};
    assign rem2_b = {i_work.rem_b, 1'b0};
    assign bit_g  = rem2_g >= {1'b0, i_geom.height};
    assign bit_b  = rem2_b >= {1'b0, i_geom.width};

    always_comb begin
        n_work       = i_work;
        n_work.rem_g = bit_g ? gtp_pkg::DIM_W'(rem2_g - {1'b0, i_geom.height})
                             : rem2_g[gtp_pkg::DIM_W-1:0];
        n_work.rem_b = bit_b ? gtp_pkg::DIM_W'(rem2_b - {1'b0, i_geom.width})
                             : rem2_b[gtp_pkg::DIM_W-1:0];
        n_work.quo_g = {i_work.quo_g[gtp_pkg::QUO_W-2:0], bit_g};
        n_work.quo_b = {i_work.quo_b[gtp_pkg::QUO_W-2:0], bit_b};
    end

    assign o_ready = !r_valid || i_ready_dn;

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_work <= n_work;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;

endmodule

FILE: rtl/core/gtp_shade.sv
// Final stage: maps the ramp steps and frame flags to a color and holds the result.
`timescale 1ns / 1ps

module gtp_shade (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gtp_pkg::t_geom      i_geom,
    input  logic                i_valid,
    input  gtp_pkg::t_work      i_work,
    output logic                o_ready,
    output logic                o_valid,
    output gtp_pkg::t_pix_out   o_pixel,
    input  logic                i_stall
);

    logic                r_valid;
    gtp_pkg::t_pix_out   r_pixel;
    gtp_pkg::t_pix_out   n_pixel;
    logic [2:0]          blue_step;

    // 16 vertical steps; 8 horizontal steps are the top bits of a 16-step quotient
    assign blue_step = i_work.quo_b[gtp_pkg::QUO_W-1:1];

    always_comb begin
        n_pixel = '0;
        if (i_work.in_range) begin
            n_pixel.in_range = 1'b1;
            if (i_geom.mode == gtp_pkg::MODE_RGB888) begin
                n_pixel.green = {i_work.quo_g, 4'b0};
                n_pixel.blue  = {blue_step, 5'b0};
            end else if (i_work.border) begin
                n_pixel.red = gtp_pkg::RED_FULL;
            end else if (i_work.col_line) begin
                n_pixel.green = gtp_pkg::GREEN_LINE;
            end else begin
                n_pixel.green = {2'b0, i_work.quo_g, 2'b0};
                n_pixel.blue  = {3'b0, blue_step, 2'b0};
            end
        end
    end

    assign o_ready = !r_valid || !i_stall;

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

endmodule

FILE: rtl/core/gradient_test_pattern_pixel.sv
// Top level of the gradient test pattern pixel generator.
// Usage:
//   Input channel i_valid/o_stall carries one pixel coordinate per item; the
//   output channel o_valid/i_stall returns its color (red, green, blue, in_range).
//   An item moves on an edge where valid is high and stall is low.
//   Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index (0 width, 1 height,
//   2 color mode) and i_cfg_data; o_cfg_ready is always high. Write only while idle.
//   Items pass the entry register, four divider steps and the output register.
//   Throughput: one item per cycle while the receiver does not stall.
//   The two ramp quotients come from a four-step restoring divider, one
//   quotient bit per stage, which sets the depth.
//   Reset (synchronous, active low) empties the pipeline and loads width 800,
//   height 480 and RGB565 mode.
//   When the receiver stalls, the output holds its item; each stage keeps
//   taking items until it is full, then o_stall rises. Nothing is lost or repeated.
`timescale 1ns / 1ps

module gradient_test_pattern_pixel #(
    parameter int MAX_DIMENSION = gtp_pkg::MAX_DIMENSION_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  gtp_pkg::t_pix_in               i_pixel,
    output logic                           o_valid,
    input  logic                           i_stall,
    output gtp_pkg::t_pix_out              o_pixel,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gtp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gtp_pkg::DIM_W-1:0]      i_cfg_data
);

    localparam int STEPS = gtp_pkg::QUO_W;

    gtp_pkg::t_geom            geom;
    gtp_pkg::t_work            s_work  [0:STEPS];
    logic                      s_valid [0:STEPS];
    logic                      s_ready [0:STEPS+1];

    logic                      r_valid0;
    gtp_pkg::t_work            r_work0;
    gtp_pkg::t_work            n_work0;
    logic [gtp_pkg::DIM_W-1:0] x_ext;
    logic [gtp_pkg::DIM_W-1:0] y_ext;

    // Configuration registers
    gtp_cfg #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom)
    );

    // Entry stage: range check and frame flags
    assign x_ext = {1'b0, i_pixel.pixel_x};
    assign y_ext = {1'b0, i_pixel.pixel_y};

    always_comb begin
        n_work0          = '0;
        n_work0.in_range = (x_ext < geom.width) && (y_ext < geom.height);
        n_work0.border   = (y_ext == '0) || (y_ext == geom.height - 13'd1) ||
                           (x_ext == '0) || (x_ext == geom.width - 13'd1);
        n_work0.col_line = (geom.width >= 13'd2) && (x_ext == geom.width - 13'd2);
        n_work0.rem_g    = y_ext;
        n_work0.rem_b    = x_ext;
    end

    assign s_ready[0] = !r_valid0 || s_ready[1];
    assign o_stall    = !s_ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (s_ready[0]) begin
            r_valid0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_ready[0] && i_valid) begin
            r_work0 <= n_work0;
        end
    end

    assign s_valid[0] = r_valid0;
    assign s_work[0]  = r_work0;

    // Divider stages, one quotient bit each
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        gtp_div_step u_step (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_geom     (geom),
            .i_valid    (s_valid[k]),
            .i_work     (s_work[k]),
            .o_ready    (s_ready[k+1]),
            .o_valid    (s_valid[k+1]),
            .o_work     (s_work[k+1]),
            .i_ready_dn (s_ready[k+2])
        );
    end

    // Color and output register
    gtp_shade u_shade (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_valid (s_valid[STEPS]),
        .i_work  (s_work[STEPS]),
        .o_ready (s_ready[STEPS+1]),
        .o_valid (o_valid),
        .o_pixel (o_pixel),
        .i_stall (i_stall)
    );

endmodule
